@@ hw/rtl/hull_slice_buoyancy_force_assert.svh @@
// Assertion macros for the hull slice buoyancy block.
// Used by the top level only; depends on clk and rst_n in the including scope.
`ifndef HULL_SLICE_BUOYANCY_FORCE_ASSERT_SVH
`define HULL_SLICE_BUOYANCY_FORCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSBF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSBF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/hsbf_pkg.sv @@
// Shared widths, constants, register codes and stage types of the hull slice
// buoyancy block. No dependencies.
`default_nettype none

package hsbf_pkg;

    localparam int POS_W      = 32;
    localparam int Q_W        = 16;
    localparam int R_W        = 21;
    localparam int LEN_W      = 23;
    localparam int CNT_W      = 7;
    localparam int DEN_W      = 16;
    localparam int G_W        = 21;
    localparam int H_W        = 22;
    localparam int U_W        = 22;
    localparam int SQ_W       = 2 * R_W;
    localparam int S_W        = R_W;
    localparam int XY_W       = 45;
    localparam int Z_W        = 34;
    localparam int TH_W       = 20;
    localparam int AREA_W     = 30;
    localparam int VOL_W      = 37;
    localparam int MASS_W     = VOL_W + DEN_W;
    localparam int PROD_W     = MASS_W + G_W;
    localparam int FORCE_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CORDIC_SHIFT = 20;
    localparam int ATAN_N     = 32;
    localparam int ANGLE_ITERATIONS_DEF = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 3'd5;

    localparam logic [R_W-1:0]   RADIUS_RST  = 21'd13959;
    localparam logic [LEN_W-1:0] LENGTH_RST  = 23'd321126;
    localparam logic [CNT_W-1:0] COUNT_RST   = 7'd1;
    localparam logic [POS_W-1:0] LEVEL_RST   = 32'd0;
    localparam logic [DEN_W-1:0] DENSITY_RST = 16'd1000;
    localparam logic [G_W-1:0]   GRAVITY_RST = 21'd642689;
    localparam logic [SQ_W-1:0]  RSQ_RST     = SQ_W'(RADIUS_RST) * SQ_W'(RADIUS_RST);

    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [FORCE_W-1:0]    FORCE_MAX   = '1;

    // Arc tangent of 2^-i in Q.30 radians.
    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd1
    };

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [R_W-1:0]          radius;
        logic [SQ_W-1:0]         r_sq;
        logic signed [POS_W-1:0] fluid_level;
        logic [DEN_W-1:0]        density;
        logic [G_W-1:0]          gravity;
        logic [LEN_W-1:0]        slice;
    } cfg_t;

    // Item state inside the square root chain.
    typedef struct packed {
        logic                  wet;
        logic signed [U_W-1:0] u;
        logic [SQ_W-1:0]       rem;
        logic [S_W-1:0]        root;
    } sq_t;

    // Item state inside the angle chain.
    typedef struct packed {
        logic                   wet;
        logic signed [U_W-1:0]  u;
        logic [S_W-1:0]         s;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cd_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsbf_front.sv @@
// Front stages: point rotation, immersion depth, clamp and r^2 - u^2.
// Depends on hsbf_pkg.
`default_nettype none

module hsbf_front
    import hsbf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] pose_z,
    input  logic signed [Q_W-1:0]   quat_w,
    input  logic signed [Q_W-1:0]   quat_x,
    input  logic signed [Q_W-1:0]   quat_y,
    input  logic signed [Q_W-1:0]   quat_z,
    input  logic signed [POS_W-1:0] local_x,
    input  logic signed [POS_W-1:0] local_y,
    input  logic signed [POS_W-1:0] local_z,
    input  logic signed [POS_W-1:0] wave_elevation,
    input  cfg_t                    cfg,
    output logic                    sq_valid,
    input  logic                    sq_ready,
    output sq_t                     sq_data
);

    localparam int C_W    = 34;
    localparam int RC_W   = 20;
    localparam int PR_W   = RC_W + POS_W;
    localparam int SUM_W  = PR_W + 2;
    localparam int RZ_W   = SUM_W - 14;
    localparam int BASE_W = POS_W + 2;
    localparam int DEP_W  = RZ_W + 2;

    localparam logic signed [C_W-1:0]   C_ONE   = C_W'(1) <<< 28;
    localparam logic signed [C_W-1:0]   C_HALF  = C_W'(1) <<< 13;
    localparam logic signed [SUM_W-1:0] S_HALF  = SUM_W'(1) <<< 13;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || sq_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: rotation coefficients of the z row in Q.28.
    logic signed [31:0]      p_xx, p_yy, p_xz, p_wy, p_yz, p_wx;
    logic signed [C_W-1:0]   cx_next, cy_next, cz_next;
    logic signed [C_W-1:0]   cx_reg, cy_reg, cz_reg;
    logic signed [POS_W-1:0] lx_reg, ly_reg, lz_reg, pz_reg, wave_reg;

    assign p_xx = quat_x * quat_x;
    assign p_yy = quat_y * quat_y;
    assign p_xz = quat_x * quat_z;
    assign p_wy = quat_w * quat_y;
    assign p_yz = quat_y * quat_z;
    assign p_wx = quat_w * quat_x;
    assign cz_next = C_ONE - ((C_W'(p_xx) + C_W'(p_yy)) <<< 1);
    assign cx_next = (C_W'(p_xz) - C_W'(p_wy)) <<< 1;
    assign cy_next = (C_W'(p_yz) + C_W'(p_wx)) <<< 1;

    // Stage 2: round coefficients to Q.14 and multiply by the point.
    logic signed [RC_W-1:0]   rcx, rcy, rcz;
    logic signed [PR_W-1:0]   prx_next, pry_next, prz_next;
    logic signed [PR_W-1:0]   prx_reg, pry_reg, prz_reg;
    logic signed [BASE_W-1:0] base_next, base2_reg, base3_reg;

    assign rcx = RC_W'((cx_reg + C_HALF) >>> 14);
    assign rcy = RC_W'((cy_reg + C_HALF) >>> 14);
    assign rcz = RC_W'((cz_reg + C_HALF) >>> 14);
    assign prx_next = PR_W'(rcx) * PR_W'(lx_reg);
    assign pry_next = PR_W'(rcy) * PR_W'(ly_reg);
    assign prz_next = PR_W'(rcz) * PR_W'(lz_reg);
    assign base_next = BASE_W'(cfg.fluid_level) + BASE_W'(wave_reg) - BASE_W'(pz_reg);

    // Stage 3: rotated z offset in Q16.16.
    logic signed [SUM_W-1:0] sum_w;
    logic signed [RZ_W-1:0]  rz_next, rz_reg;

    assign sum_w = SUM_W'(prx_reg) + SUM_W'(pry_reg) + SUM_W'(prz_reg);
    assign rz_next = RZ_W'((sum_w + S_HALF) >>> 14);

    // Stage 4: depth, clamp to the diameter, u = r - h.
    logic signed [DEP_W-1:0] depth_w, two_r_s;
    logic [H_W-1:0]          two_r, h_w;
    logic                    wet_next, wet4_reg, wet5_reg;
    logic signed [U_W-1:0]   u_next, u4_reg, u5_reg;

    assign depth_w  = DEP_W'(base3_reg) - DEP_W'(rz_reg);
    assign two_r    = H_W'(cfg.radius) << 1;
    assign two_r_s  = DEP_W'(two_r);
    assign h_w      = (depth_w > two_r_s) ? two_r : depth_w[H_W-1:0];
    assign wet_next = !depth_w[DEP_W-1] && (depth_w != '0) && (two_r != '0);
    assign u_next   = $signed(U_W'(cfg.radius) - h_w);

    // Stage 5: radicand of the half chord.
    logic signed [2*U_W-1:0] u_sq_full;
    logic [SQ_W-1:0]         rem_next, rem_reg;

    assign u_sq_full = u4_reg * u4_reg;
    assign rem_next  = cfg.r_sq - u_sq_full[SQ_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cz_reg   <= cz_next;
            lx_reg   <= local_x;
            ly_reg   <= local_y;
            lz_reg   <= local_z;
            pz_reg   <= pose_z;
            wave_reg <= wave_elevation;
        end
        if (en2)
        begin
            prx_reg   <= prx_next;
            pry_reg   <= pry_next;
            prz_reg   <= prz_next;
            base2_reg <= base_next;
        end
        if (en3)
        begin
            rz_reg    <= rz_next;
            base3_reg <= base2_reg;
        end
        if (en4)
        begin
            wet4_reg <= wet_next;
            u4_reg   <= u_next;
        end
        if (en5)
        begin
            wet5_reg <= wet4_reg;
            u5_reg   <= u4_reg;
            rem_reg  <= rem_next;
        end
    end

    assign sq_valid     = v5_reg;
    assign sq_data.wet  = wet5_reg;
    assign sq_data.u    = u5_reg;
    assign sq_data.rem  = rem_reg;
    assign sq_data.root = '0;

endmodule

`default_nettype wire

@@ hw/rtl/hsbf_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit per item.
// Depends on hsbf_pkg.
`default_nettype none

module hsbf_sqrt_cell
    import hsbf_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  sq_t  up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output sq_t  dn_data
);

    localparam int TR_W = SQ_W + 1;

    logic            v_reg;
    sq_t             d_reg, d_next;
    logic [TR_W-1:0] trial;
    logic            take;

    assign up_ready = !v_reg || dn_ready;

    // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
    assign trial = (TR_W'(up_data.root) << (BIT + 1)) + (TR_W'(1) << (2 * BIT));
    assign take  = TR_W'(up_data.rem) >= trial;

    always_comb
    begin
        d_next = up_data;
        if (take)
        begin
            d_next.rem  = up_data.rem - trial[SQ_W-1:0];
            d_next.root = up_data.root | (S_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hsbf_cordic_cell.sv @@
// One cell of the vectoring angle chain: one micro-rotation per item.
// Depends on hsbf_pkg.
`default_nettype none

module hsbf_cordic_cell
    import hsbf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  cd_t  up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output cd_t  dn_data
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_Q30[IDX]);

    logic                   v_reg;
    cd_t                    d_reg, d_next;
    logic signed [XY_W-1:0] dx, dy;
    logic                   y_pos;

    assign up_ready = !v_reg || dn_ready;
    assign dx    = up_data.y >>> IDX;
    assign dy    = up_data.x >>> IDX;
    assign y_pos = !up_data.y[XY_W-1] && (up_data.y != '0);

    always_comb
    begin
        d_next = up_data;
        if (y_pos)
        begin
            d_next.x = up_data.x + dx;
            d_next.y = up_data.y - dy;
            d_next.z = up_data.z + ATAN_STEP;
        end
        else
        begin
            d_next.x = up_data.x - dx;
            d_next.y = up_data.y + dy;
            d_next.z = up_data.z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
            d_reg <= d_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = d_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hsbf_back.sv @@
// Back stages: segment area, volume, mass, force with rounding and saturation,
// and the output register. Depends on hsbf_pkg.
`default_nettype none

module hsbf_back
    import hsbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cd_valid,
    output logic               cd_ready,
    input  cd_t                cd_data,
    input  cfg_t               cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FORCE_W-1:0] force_up,
    output logic               submerged,
    output logic               force_saturated
);

    localparam int P1_W = SQ_W + TH_W;
    localparam int P2_W = U_W + S_W;
    localparam int AR_W = 64;
    localparam int VP_W = AREA_W + LEN_W;
    localparam int T_W  = PROD_W + 1;
    localparam int F_W  = T_W - 24;

    localparam logic signed [Z_W-1:0]  Z_HALF  = Z_W'(1) <<< 11;
    localparam logic signed [AR_W-1:0] A_HALF  = AR_W'(1) <<< 33;
    localparam logic [VP_W-1:0]        V_HALF  = VP_W'(1) << 15;
    localparam logic [T_W-1:0]         F_HALF  = T_W'(1) << 23;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_v_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !out_v_reg || !out_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign cd_ready = en1;

    // Stage 1: clamp the angle, round to Q.18, form both area products.
    logic signed [Z_W-1:0]  z_clamp;
    logic [TH_W-1:0]        th_w;
    logic [P1_W-1:0]        p1_next, p1_reg;
    logic signed [P2_W-1:0] p2_next, p2_reg;
    logic                   wet1_reg, wet2_reg, wet3_reg, wet4_reg, wet5_reg;

    always_comb
    begin
        if (cd_data.z[Z_W-1])
            z_clamp = '0;
        else if (cd_data.z > PI_Q30)
            z_clamp = PI_Q30;
        else
            z_clamp = cd_data.z;
    end

    assign th_w    = TH_W'((z_clamp + Z_HALF) >>> 12);
    assign p1_next = P1_W'(cfg.r_sq) * P1_W'(th_w);
    assign p2_next = P2_W'(cd_data.u) * $signed(P2_W'(cd_data.s));

    // Stage 2: area in Q.50, floored at zero, rounded to Q16.16.
    logic signed [AR_W-1:0] area_w;
    logic [AREA_W-1:0]      area_next, area_reg;

    assign area_w    = $signed(AR_W'(p1_reg)) - (AR_W'(p2_reg) <<< 18);
    assign area_next = area_w[AR_W-1] ? '0 : AREA_W'((area_w + A_HALF) >>> 34);

    // Stages 3 to 5: volume, mass and the full force product.
    logic [VP_W-1:0]   vp_w;
    logic [VOL_W-1:0]  vol_reg;
    logic [MASS_W-1:0] mass_reg;
    logic [PROD_W-1:0] prod_reg;

    assign vp_w = VP_W'(area_reg) * VP_W'(cfg.slice);

    // Stage 6: round Q.32 to Q.8 and saturate.
    logic [T_W-1:0]     t_w;
    logic [F_W-1:0]     f_w;
    logic               sat_w;

    assign t_w   = T_W'(prod_reg) + F_HALF;
    assign f_w   = F_W'(t_w >> 24);
    assign sat_w = |f_w[F_W-1:FORCE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            out_v_reg       <= 1'b0;
            force_up        <= '0;
            submerged       <= 1'b0;
            force_saturated <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= cd_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6)
            begin
                out_v_reg <= v5_reg;
                if (!wet5_reg)
                begin
                    force_up        <= '0;
                    submerged       <= 1'b0;
                    force_saturated <= 1'b0;
                end
                else
                begin
                    force_up        <= sat_w ? FORCE_MAX : f_w[FORCE_W-1:0];
                    submerged       <= 1'b1;
                    force_saturated <= sat_w;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            wet1_reg <= cd_data.wet;
        end
        if (en2)
        begin
            area_reg <= area_next;
            wet2_reg <= wet1_reg;
        end
        if (en3)
        begin
            vol_reg  <= VOL_W'((vp_w + V_HALF) >> 16);
            wet3_reg <= wet2_reg;
        end
        if (en4)
        begin
            mass_reg <= MASS_W'(vol_reg) * MASS_W'(cfg.density);
            wet4_reg <= wet3_reg;
        end
        if (en5)
        begin
            prod_reg <= PROD_W'(mass_reg) * PROD_W'(cfg.gravity);
            wet5_reg <= wet4_reg;
        end
    end

    assign out_valid = out_v_reg;

endmodule

`default_nettype wire

@@ hw/rtl/hull_slice_buoyancy_force.sv @@
// Hull slice buoyancy force, top level. Takes one sample point per cycle while
// in_stall is low and returns its upward force through five front stages for
// rotation and depth, a chain of 21 square root cells (one root bit each), a
// chain of ANGLE_ITERATIONS angle cells (capped at ATAN_N, one micro-rotation each)
// and six back stages for area, volume, mass, force and the output register.
// Every cell passes its item on whenever the next can take it, so the sustained
// rate is one transaction per cycle on both channels while nothing stalls; a
// stalled output holds the output register, earlier stages keep filling their
// empty slots, and once all are full in_stall rises. Configuration writes are
// always taken. A hull length or point count write restarts the slice divider,
// which is done long before a later item reaches the stage that uses the slice.
// There is no memory and no clearing pass after reset.
// Depends on hsbf_pkg, the cell and stage modules and the assertion header.
`default_nettype none

`include "hull_slice_buoyancy_force_assert.svh"

module hull_slice_buoyancy_force
    import hsbf_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [POS_W-1:0] pose_z,
    input  logic signed [Q_W-1:0]   quat_w,
    input  logic signed [Q_W-1:0]   quat_x,
    input  logic signed [Q_W-1:0]   quat_y,
    input  logic signed [Q_W-1:0]   quat_z,
    input  logic signed [POS_W-1:0] local_x,
    input  logic signed [POS_W-1:0] local_y,
    input  logic signed [POS_W-1:0] local_z,
    input  logic signed [POS_W-1:0] wave_elevation,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [FORCE_W-1:0]      force_up,
    output logic                    submerged,
    output logic                    force_saturated
);

    localparam int CORDIC_N  = (ANGLE_ITERATIONS < ATAN_N) ? ANGLE_ITERATIONS : ATAN_N;
    localparam int DIV_CNT_W = $clog2(LEN_W + 1);

    // Configuration registers. The port never pushes back.
    logic [R_W-1:0]   radius_reg;
    logic [LEN_W-1:0] length_reg;
    logic [CNT_W-1:0] count_reg;
    logic [POS_W-1:0] level_reg;
    logic [DEN_W-1:0] density_reg;
    logic [G_W-1:0]   gravity_reg;
    logic [SQ_W-1:0]  r_sq_reg;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RST;
            length_reg  <= LENGTH_RST;
            count_reg   <= COUNT_RST;
            level_reg   <= LEVEL_RST;
            density_reg <= DENSITY_RST;
            gravity_reg <= GRAVITY_RST;
            r_sq_reg    <= RSQ_RST;
        end
        else
        begin
            r_sq_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_RADIUS:  radius_reg  <= cfg_data[R_W-1:0];
                    CFG_LENGTH:  length_reg  <= cfg_data[LEN_W-1:0];
                    CFG_COUNT:   count_reg   <= cfg_data[CNT_W-1:0];
                    CFG_LEVEL:   level_reg   <= cfg_data[POS_W-1:0];
                    CFG_DENSITY: density_reg <= cfg_data[DEN_W-1:0];
                    CFG_GRAVITY: gravity_reg <= cfg_data[G_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Slice length = hull length / point count, one quotient bit per cycle.
    // The quotient register holds the slice length once the count runs out.
    logic                 div_load_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [LEN_W-1:0]     div_quo_reg;
    logic [CNT_W-1:0]     div_rem_reg;
    logic [CNT_W-1:0]     div_den;
    logic [CNT_W:0]       div_shift;
    logic                 div_bit;

    assign div_den   = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign div_shift = {div_rem_reg, div_quo_reg[LEN_W-1]};
    assign div_bit   = div_shift >= {1'b0, div_den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_load_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_quo_reg  <= LENGTH_RST;
            div_rem_reg  <= '0;
        end
        else
        begin
            div_load_reg <= cfg_wr && ((cfg_index == CFG_LENGTH) || (cfg_index == CFG_COUNT));
            if (div_load_reg)
            begin
                div_cnt_reg <= DIV_CNT_W'(LEN_W);
                div_quo_reg <= length_reg;
                div_rem_reg <= '0;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
                div_quo_reg <= {div_quo_reg[LEN_W-2:0], div_bit};
                div_rem_reg <= div_bit ? CNT_W'(div_shift - {1'b0, div_den})
                                       : div_shift[CNT_W-1:0];
            end
        end
    end

    cfg_t cfg;

    assign cfg.radius      = radius_reg;
    assign cfg.r_sq        = r_sq_reg;
    assign cfg.fluid_level = $signed(level_reg);
    assign cfg.density     = density_reg;
    assign cfg.gravity     = gravity_reg;
    assign cfg.slice       = div_quo_reg;

    // Front stages.
    logic sq_v [S_W+1];
    logic sq_r [S_W+1];
    sq_t  sq_d [S_W+1];
    logic in_ready;

    assign in_stall = !in_ready;

    hsbf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pose_z         (pose_z),
        .quat_w         (quat_w),
        .quat_x         (quat_x),
        .quat_y         (quat_y),
        .quat_z         (quat_z),
        .local_x        (local_x),
        .local_y        (local_y),
        .local_z        (local_z),
        .wave_elevation (wave_elevation),
        .cfg            (cfg),
        .sq_valid       (sq_v[0]),
        .sq_ready       (sq_r[0]),
        .sq_data        (sq_d[0])
    );

    // Square root chain, most significant root bit first.
    for (genvar k = 0; k < S_W; k++)
    begin : g_sqrt
        hsbf_sqrt_cell #(
            .BIT (S_W - 1 - k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_v[k]),
            .up_ready (sq_r[k]),
            .up_data  (sq_d[k]),
            .dn_valid (sq_v[k+1]),
            .dn_ready (sq_r[k+1]),
            .dn_data  (sq_d[k+1])
        );
    end

    // Angle chain entry: atan2(s, u) with inputs scaled by 2^20. A negative u
    // is turned by a quarter turn first so the vector starts in the right half.
    logic cd_v [CORDIC_N+1];
    logic cd_r [CORDIC_N+1];
    cd_t  cd_d [CORDIC_N+1];
    logic signed [XY_W-1:0] u_sc, s_sc;

    assign u_sc = XY_W'(sq_d[S_W].u) <<< CORDIC_SHIFT;
    assign s_sc = $signed(XY_W'(sq_d[S_W].root) << CORDIC_SHIFT);

    assign cd_v[0]      = sq_v[S_W];
    assign sq_r[S_W]    = cd_r[0];
    assign cd_d[0].wet  = sq_d[S_W].wet;
    assign cd_d[0].u    = sq_d[S_W].u;
    assign cd_d[0].s    = sq_d[S_W].root;
    assign cd_d[0].x    = sq_d[S_W].u[U_W-1] ? s_sc : u_sc;
    assign cd_d[0].y    = sq_d[S_W].u[U_W-1] ? -u_sc : s_sc;
    assign cd_d[0].z    = sq_d[S_W].u[U_W-1] ? HALF_PI_Q30 : '0;

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_cordic
        hsbf_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cd_v[i]),
            .up_ready (cd_r[i]),
            .up_data  (cd_d[i]),
            .dn_valid (cd_v[i+1]),
            .dn_ready (cd_r[i+1]),
            .dn_data  (cd_d[i+1])
        );
    end

    // Area, volume, mass, force and the output register.
    hsbf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cd_valid        (cd_v[CORDIC_N]),
        .cd_ready        (cd_r[CORDIC_N]),
        .cd_data         (cd_d[CORDIC_N]),
        .cfg             (cfg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .force_up        (force_up),
        .submerged       (submerged),
        .force_saturated (force_saturated)
    );

    // A dry point carries no force and no saturation flag.
    `HSBF_ASSERT_IMP(a_dry_zero, out_valid && !submerged, (force_up == '0) && !force_saturated, "dry point with nonzero force")
    // Saturation only happens on a submerged point and pins the force at full scale.
    `HSBF_ASSERT_IMP(a_sat_full, out_valid && force_saturated, submerged && (force_up == FORCE_MAX), "saturated force not at full scale")
    // A point count write starts the slice divider on the next cycle.
    `HSBF_ASSERT_NXT(a_div_start, cfg_wr && (cfg_index == CFG_COUNT), div_load_reg, "slice divider not restarted")

endmodule

`default_nettype wire
